### sv/directional_difference_energy_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for directional_difference_energy
// Short forms for clocked concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIRECTIONAL_DIFFERENCE_ENERGY_MACROS_SVH
`define DIRECTIONAL_DIFFERENCE_ENERGY_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define DDE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define DDE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/dde_pkg.sv
// ----------------------------------------------------------------------------
// dde_pkg
// Shared constants, word types and helper functions of the directional
// difference energy block.
// ----------------------------------------------------------------------------
package dde_pkg;

	// Frame memory geometry
	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(DEPTH);

	// Field widths
	localparam int COL_W    = 9;
	localparam int ROW_W    = 9;
	localparam int PIX_W    = 8;
	localparam int DIST_W   = 9;
	localparam int CFG_W    = 10;
	localparam int ENERGY_W = 17;
	localparam int TERM_W   = 2 * PIX_W;

	// Clamped coordinate widths and limited image size widths
	localparam int XC_W = $clog2(MAX_WIDTH);
	localparam int YC_W = $clog2(MAX_HEIGHT);
	localparam int WD_W = $clog2(MAX_WIDTH + 1);
	localparam int HT_W = $clog2(MAX_HEIGHT + 1);

	// Width for coordinate arithmetic: holds any size, coordinate or sum
	localparam int DIM_A_W = (WD_W > HT_W) ? WD_W : HT_W;
	localparam int CW      = ((DIM_A_W > CFG_W) ? DIM_A_W : CFG_W) + 1;

	// Item modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_DISTANCE     = 2'd2,
		CFG_QUADRATIC    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic             mode;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [PIX_W-1:0] pixel_value;
	} in_word_t;

	typedef struct packed {
		logic [ENERGY_W-1:0] horizontal_energy;
		logic [ENERGY_W-1:0] vertical_energy;
		logic [ENERGY_W-1:0] diagonal_energy;
	} out_word_t;

	// Single-port frame memory request
	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  wdata;
	} mem_req_t;

	// Linear frame address of pixel (x, y)
	function automatic logic [ADDR_W-1:0] pix_addr(logic [XC_W-1:0] x, logic [YC_W-1:0] y);
		return ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
	endfunction

	// Limit a written width to 1..MAX_WIDTH
	function automatic logic [WD_W-1:0] lim_width(logic [CFG_W-1:0] v);
		if (v == '0)
			return WD_W'(1);
		else if (CW'(v) > CW'(MAX_WIDTH))
			return WD_W'(MAX_WIDTH);
		else
			return WD_W'(v);
	endfunction

	// Limit a written height to 1..MAX_HEIGHT
	function automatic logic [HT_W-1:0] lim_height(logic [CFG_W-1:0] v);
		if (v == '0)
			return HT_W'(1);
		else if (CW'(v) > CW'(MAX_HEIGHT))
			return HT_W'(MAX_HEIGHT);
		else
			return HT_W'(v);
	endfunction

endpackage

### sv/dde_frame_mem.sv
// ----------------------------------------------------------------------------
// dde_frame_mem
// Single-port synchronous frame memory of gray pixels, one access per cycle,
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module dde_frame_mem (
	input  logic                      clk,
	input  dde_pkg::mem_req_t         req,
	output logic [dde_pkg::PIX_W-1:0] rdata
);

	logic [dde_pkg::PIX_W-1:0] mem [dde_pkg::DEPTH];

	// Write or read one entry
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata <= mem[req.addr];
			end
		end
	end

endmodule

### sv/directional_difference_energy.sv
// ----------------------------------------------------------------------------
// directional_difference_energy
// Frame memory with horizontal, vertical and diagonal difference energies.
// ----------------------------------------------------------------------------
// A write word stores one pixel and produces no result. A query
// word reads seven pixels (center, then the left/right, up/down and
// up-left/down-right neighbors at the configured distance, clamped to the
// image) one after another through the single port of the frame memory.
// A query holds the input while it runs: its position is clamped as it is
// taken, an address step reads the center and registers the neighbor
// positions, six more read steps follow, the read and term registers drain
// and the result goes to the output register once the output is free. The
// result stays there while the next word is taken. Each channel is the sum
// of two absolute or two squared differences, i.e. twice the half-weighted
// energy. Pixels must be written before they are queried.
// ----------------------------------------------------------------------------
`include "directional_difference_energy_macros.svh"

module directional_difference_energy (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_write,
	input  logic [1:0]                 cfg_index,
	input  logic [dde_pkg::CFG_W-1:0]  cfg_data,
	// input words
	input  logic                       in_valid,
	output logic                       in_stall,
	input  dde_pkg::in_word_t          in_data,
	// result words
	output logic                       out_valid,
	input  logic                       out_stall,
	output dde_pkg::out_word_t         out_data
);

	localparam int CW   = dde_pkg::CW;
	localparam int XC_W = dde_pkg::XC_W;
	localparam int YC_W = dde_pkg::YC_W;

	// Read slot order
	localparam logic [2:0] RD_CENTER    = 3'd0;
	localparam logic [2:0] RD_LEFT      = 3'd1;
	localparam logic [2:0] RD_RIGHT     = 3'd2;
	localparam logic [2:0] RD_UP        = 3'd3;
	localparam logic [2:0] RD_DOWN      = 3'd4;
	localparam logic [2:0] RD_UPLEFT    = 3'd5;
	localparam logic [2:0] RD_DOWNRIGHT = 3'd6;
	localparam logic [2:0] RD_LAST      = RD_DOWNRIGHT;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_READ,
		ST_TAIL,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [dde_pkg::WD_W-1:0]   width_q;
	logic [dde_pkg::HT_W-1:0]   height_q;
	logic [dde_pkg::DIST_W-1:0] dist_q;
	logic                       quad_q;

	// Query coordinates
	logic [XC_W-1:0] x_q, xl_q, xr_q;
	logic [YC_W-1:0] y_q, yl_q, yr_q;
	logic [2:0]      cnt_q;

	// Read and term pipeline
	logic                           rd_v_s1;
	logic [2:0]                     rd_idx_s1;
	logic [dde_pkg::PIX_W-1:0]      a_q;
	logic                           term_v_s2;
	logic [2:0]                     term_idx_s2;
	logic [dde_pkg::TERM_W-1:0]     term_s2;
	logic [dde_pkg::ENERGY_W-1:0]   acc_h_q, acc_v_q, acc_d_q;

	// Output register
	logic               out_valid_q;
	dde_pkg::out_word_t out_data_q;

	// Memory port
	dde_pkg::mem_req_t         mem_req;
	logic [dde_pkg::PIX_W-1:0] mem_rdata;

	logic in_acc;
	logic wr_en;
	logic rd_issue;
	logic out_free;
	logic [2:0] rd_idx;

	logic [CW-1:0] col_c, row_c, w_c, h_c, x_cl, y_cl, e_c;
	logic [CW-1:0] x_c, y_c, xsum, ysum, xl_c, xr_c, yl_c, yr_c;
	logic [XC_W-1:0] rd_x;
	logic [YC_W-1:0] rd_y;

	logic [dde_pkg::PIX_W-1:0]  diff;
	logic [dde_pkg::TERM_W-1:0] sq;
	logic [dde_pkg::TERM_W-1:0] term;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Clamp the query position to the image
	assign col_c = CW'(in_data.col);
	assign row_c = CW'(in_data.row);
	assign w_c   = CW'(width_q);
	assign h_c   = CW'(height_q);
	assign x_cl  = (col_c >= w_c) ? (w_c - CW'(1)) : col_c;
	assign y_cl  = (row_c >= h_c) ? (h_c - CW'(1)) : row_c;

	// Neighbor positions at the configured distance, clamped to the edges
	assign e_c  = CW'(dist_q);
	assign x_c  = CW'(x_q);
	assign y_c  = CW'(y_q);
	assign xsum = x_c + e_c;
	assign ysum = y_c + e_c;
	assign xl_c = (x_c >= e_c) ? (x_c - e_c) : '0;
	assign xr_c = (xsum < w_c) ? xsum : (w_c - CW'(1));
	assign yl_c = (y_c >= e_c) ? (y_c - e_c) : '0;
	assign yr_c = (ysum < h_c) ? ysum : (h_c - CW'(1));

	// Pick the coordinates of the current read slot
	assign rd_idx   = (state_q == ST_ADDR) ? RD_CENTER : cnt_q;
	assign rd_issue = (state_q == ST_ADDR) || (state_q == ST_READ);

	always_comb begin
		case (rd_idx) inside
			RD_LEFT, RD_UPLEFT:     rd_x = xl_q;
			RD_RIGHT, RD_DOWNRIGHT: rd_x = xr_q;
			default:                rd_x = x_q;
		endcase
		case (rd_idx) inside
			RD_UP, RD_UPLEFT:       rd_y = yl_q;
			RD_DOWN, RD_DOWNRIGHT:  rd_y = yr_q;
			default:                rd_y = y_q;
		endcase
	end

	// Memory request: pixel store in idle, reads during a query
	assign wr_en = in_acc && (in_data.mode == dde_pkg::MODE_WRITE)
		&& (col_c < CW'(dde_pkg::MAX_WIDTH)) && (row_c < CW'(dde_pkg::MAX_HEIGHT));

	always_comb begin
		mem_req.en    = wr_en || rd_issue;
		mem_req.we    = wr_en;
		mem_req.wdata = in_data.pixel_value;
		if (wr_en) begin
			mem_req.addr = dde_pkg::pix_addr(col_c[XC_W-1:0], row_c[YC_W-1:0]);
		end else begin
			mem_req.addr = dde_pkg::pix_addr(rd_x, rd_y);
		end
	end

	dde_frame_mem u_frame_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= dde_pkg::lim_width(dde_pkg::CFG_W'(512));
			height_q <= dde_pkg::lim_height(dde_pkg::CFG_W'(512));
			dist_q   <= dde_pkg::DIST_W'(1);
			quad_q   <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				dde_pkg::CFG_IMAGE_WIDTH:  width_q  <= dde_pkg::lim_width(cfg_data);
				dde_pkg::CFG_IMAGE_HEIGHT: height_q <= dde_pkg::lim_height(cfg_data);
				dde_pkg::CFG_DISTANCE:     dist_q   <= cfg_data[dde_pkg::DIST_W-1:0];
				dde_pkg::CFG_QUADRATIC:    quad_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer: accept, address, read steps, drain, hand over result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new result or drop the one just taken
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_data.mode == dde_pkg::MODE_QUERY)) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					cnt_q   <= RD_LEFT;
					state_q <= ST_READ;
				end
				ST_READ: begin
					if (cnt_q == RD_LAST) begin
						state_q <= ST_TAIL;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_TAIL: begin
					if (term_v_s2 && (term_idx_s2 == RD_LAST)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Query coordinates and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= x_cl[XC_W-1:0];
			y_q <= y_cl[YC_W-1:0];
		end
		if (state_q == ST_ADDR) begin
			xl_q <= xl_c[XC_W-1:0];
			xr_q <= xr_c[XC_W-1:0];
			yl_q <= yl_c[YC_W-1:0];
			yr_q <= yr_c[YC_W-1:0];
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_data_q.horizontal_energy <= acc_h_q;
			out_data_q.vertical_energy   <= acc_v_q;
			out_data_q.diagonal_energy   <= acc_d_q;
		end
	end

	// Difference term against the center pixel
	always_comb begin
		diff = (mem_rdata > a_q) ? (mem_rdata - a_q) : (a_q - mem_rdata);
		sq   = dde_pkg::TERM_W'(diff) * dde_pkg::TERM_W'(diff);
		term = quad_q ? sq : dde_pkg::TERM_W'(diff);
	end

	// Read and term pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1   <= 1'b0;
			term_v_s2 <= 1'b0;
		end else begin
			rd_v_s1   <= rd_issue;
			term_v_s2 <= rd_v_s1 && (rd_idx_s1 != RD_CENTER);
		end
	end

	// Latch center, register terms, accumulate per channel
	always_ff @(posedge clk) begin
		rd_idx_s1   <= rd_idx;
		term_idx_s2 <= rd_idx_s1;
		term_s2     <= term;
		if (rd_v_s1 && (rd_idx_s1 == RD_CENTER)) begin
			a_q <= mem_rdata;
		end
		if (state_q == ST_ADDR) begin
			acc_h_q <= '0;
			acc_v_q <= '0;
			acc_d_q <= '0;
		end else if (term_v_s2) begin
			case (term_idx_s2) inside
				[RD_LEFT:RD_RIGHT]: acc_h_q <= acc_h_q + dde_pkg::ENERGY_W'(term_s2);
				[RD_UP:RD_DOWN]:    acc_v_q <= acc_v_q + dde_pkg::ENERGY_W'(term_s2);
				default:            acc_d_q <= acc_d_q + dde_pkg::ENERGY_W'(term_s2);
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Checks
	`DDE_ASSERT_IMP(a_write_only_idle, mem_req.en && mem_req.we, state_q == ST_IDLE, "pixel store outside idle")
	`DDE_ASSERT_NXT(a_query_starts, in_acc && (in_data.mode == dde_pkg::MODE_QUERY), state_q == ST_ADDR, "query did not start")
	`DDE_ASSERT_IMP(a_last_term_in_tail, term_v_s2 && (term_idx_s2 == RD_LAST), state_q == ST_TAIL, "last term outside drain")
	`DDE_ASSERT_IMP(a_result_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE, "result raised outside hand-over")

endmodule

### bench/directional_difference_energy_checker.sv
// ----------------------------------------------------------------------------
// dde_energy_checker
// Watches the configuration port and both word channels of the directional
// difference energy block, keeps its own copy of the frame and the registers,
// predicts the three channel energies of every accepted query and compares
// each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dde_energy_checker
	import dde_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  in_word_t            in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  out_word_t           out_data,
	output int                  error_count,
	output int                  pending_results
);

	// Mirror of the frame and of the registers
	logic [PIX_W-1:0]  pixel_mirror [DEPTH];
	logic [CFG_W-1:0]  width_reg;
	logic [CFG_W-1:0]  height_reg;
	logic [DIST_W-1:0] dist_reg;
	logic              quad_reg;

	// Energies predicted for queries whose result has not come yet
	out_word_t energy_queue [$];

	function automatic logic [PIX_W-1:0] pixel_at(int x, int y);
		return pixel_mirror[y * MAX_WIDTH + x];
	endfunction

	// One difference term: absolute or squared
	function automatic logic [ENERGY_W-1:0] diff_term(logic [PIX_W-1:0] n, logic [PIX_W-1:0] a);
		logic [TERM_W-1:0] d;
		d = (n > a) ? TERM_W'(n - a) : TERM_W'(a - n);
		return quad_reg ? ENERGY_W'(d * d) : ENERGY_W'(d);
	endfunction

	// Clamp the position and neighbors, then sum the two terms per direction
	function automatic out_word_t predict_energy(logic [COL_W-1:0] qc, logic [ROW_W-1:0] qr);
		int w, h, e, x, y, xl, xr, yl, yr;
		logic [PIX_W-1:0] a;
		out_word_t r;
		w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
		h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
		x = (int'(qc) >= w) ? w - 1 : int'(qc);
		y = (int'(qr) >= h) ? h - 1 : int'(qr);
		e = int'(dist_reg);
		xl = (x >= e) ? x - e : 0;
		xr = (x + e < w) ? x + e : w - 1;
		yl = (y >= e) ? y - e : 0;
		yr = (y + e < h) ? y + e : h - 1;
		a = pixel_at(x, y);
		r.horizontal_energy = diff_term(pixel_at(xl, y), a) + diff_term(pixel_at(xr, y), a);
		r.vertical_energy   = diff_term(pixel_at(x, yl), a) + diff_term(pixel_at(x, yr), a);
		r.diagonal_energy   = diff_term(pixel_at(xl, yl), a) + diff_term(pixel_at(xr, yr), a);
		return r;
	endfunction

	// Track registers, frame writes and queries; compare result words
	always @(posedge clk or negedge arst_n) begin
		int fails;
		out_word_t want;
		fails = 0;
		if (!arst_n) begin
			width_reg = CFG_W'(MAX_WIDTH);
			height_reg = CFG_W'(MAX_HEIGHT);
			dist_reg = DIST_W'(1);
			quad_reg = 1'b1;
			energy_queue.delete();
			error_count <= 0;
			pending_results <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					CFG_IMAGE_WIDTH:  width_reg = cfg_data;
					CFG_IMAGE_HEIGHT: height_reg = cfg_data;
					CFG_DISTANCE:     dist_reg = cfg_data[DIST_W-1:0];
					CFG_QUADRATIC:    quad_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (in_data.mode == MODE_WRITE)
					pixel_mirror[int'(in_data.row) * MAX_WIDTH + int'(in_data.col)] = in_data.pixel_value;
				else
					energy_queue.push_back(predict_energy(in_data.col, in_data.row));
			end
			if (out_valid && !out_stall) begin
				if (energy_queue.size() == 0) begin
					$error("result word with no query waiting: %0d %0d %0d",
						out_data.horizontal_energy, out_data.vertical_energy,
						out_data.diagonal_energy);
					fails++;
				end else begin
					want = energy_queue.pop_front();
					if (out_data.horizontal_energy !== want.horizontal_energy) begin
						$error("horizontal_energy: expected %0d, actual %0d",
							want.horizontal_energy, out_data.horizontal_energy);
						fails++;
					end
					if (out_data.vertical_energy !== want.vertical_energy) begin
						$error("vertical_energy: expected %0d, actual %0d",
							want.vertical_energy, out_data.vertical_energy);
						fails++;
					end
					if (out_data.diagonal_energy !== want.diagonal_energy) begin
						$error("diagonal_energy: expected %0d, actual %0d",
							want.diagonal_energy, out_data.diagonal_energy);
						fails++;
					end
				end
			end
			error_count <= error_count + fails;
			pending_results <= energy_queue.size();
		end
	end

endmodule

### bench/tb_directional_difference_energy.sv
// ----------------------------------------------------------------------------
// tb_directional_difference_energy
// Drives pixel writes, queries and register settings into the directional
// difference energy block with random gaps and result stalls. A checker
// beside the block predicts and compares every result word; this module
// makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_directional_difference_energy;
	import dde_pkg::*;

	localparam int RANDOM_WORDS = 750;
	localparam int DRAIN_CYCLES = 20;
	localparam int LIMIT_CYCLES = 600000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_word_t          in_data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_word_t         out_data;
	int                error_count;
	int                pending_results;

	// Stimulus state: image size as the block sees it and the pixels written
	int img_w = MAX_WIDTH;
	int img_h = MAX_HEIGHT;
	int img_dist = 1;
	bit written_map [DEPTH];
	int words_sent = 0;
	int gap_max = 11;
	int stall_max = 11;
	int stall_left = 0;
	int cycle_count = 0;

	directional_difference_energy dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	dde_energy_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.error_count     (error_count),
		.pending_results (pending_results)
	);

	always #6 clk = ~clk;

	// Stall each result word for a drawn number of cycles while it waits
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			stall_left = $urandom_range(0, stall_max);
			out_stall <= (stall_left > 0);
		end else if (out_valid && stall_left > 0) begin
			stall_left--;
			out_stall <= (stall_left > 0);
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb_directional_difference_energy failed");
			$finish;
		end
	end

	function automatic int limit_size(int v);
		if (v == 0)
			return 1;
		return (v > MAX_WIDTH) ? MAX_WIDTH : v;
	endfunction

	function automatic logic [PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Hold a word after a drawn gap until the block takes it
	task automatic send_word(input in_word_t w);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic write_word(input int x, input int y, input logic [PIX_W-1:0] v);
		in_word_t w;
		w.mode = MODE_WRITE;
		w.col = COL_W'(x);
		w.row = ROW_W'(y);
		w.pixel_value = v;
		written_map[y * MAX_WIDTH + x] = 1'b1;
		send_word(w);
	endtask

	task automatic fill_pixel(input int x, input int y);
		if (!written_map[y * MAX_WIDTH + x])
			write_word(x, y, random_pixel());
	endtask

	// Write any of the seven pixels a query reads that are still blank, then query
	task automatic query_word(input int x, input int y);
		int cx, cy, xl, xr, yl, yr;
		in_word_t w;
		cx = (x >= img_w) ? img_w - 1 : x;
		cy = (y >= img_h) ? img_h - 1 : y;
		xl = (cx >= img_dist) ? cx - img_dist : 0;
		xr = (cx + img_dist < img_w) ? cx + img_dist : img_w - 1;
		yl = (cy >= img_dist) ? cy - img_dist : 0;
		yr = (cy + img_dist < img_h) ? cy + img_dist : img_h - 1;
		fill_pixel(cx, cy);
		fill_pixel(xl, cy);
		fill_pixel(xr, cy);
		fill_pixel(cx, yl);
		fill_pixel(cx, yr);
		fill_pixel(xl, yl);
		fill_pixel(xr, yr);
		w.mode = MODE_QUERY;
		w.col = COL_W'(x);
		w.row = ROW_W'(y);
		w.pixel_value = PIX_W'($urandom_range(0, 255));
		send_word(w);
	endtask

	// Drop valid and wait until every result has come and the block is quiet
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all four registers on consecutive cycles; call only when drained
	task automatic set_config(input int w, input int h, input int d, input int q);
		cfg_write <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= CFG_W'(w);
		@(posedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data <= CFG_W'(h);
		@(posedge clk);
		cfg_index <= CFG_DISTANCE;
		cfg_data <= CFG_W'(d);
		@(posedge clk);
		cfg_index <= CFG_QUADRATIC;
		cfg_data <= CFG_W'(q);
		@(posedge clk);
		cfg_write <= 1'b0;
		img_w = limit_size(w);
		img_h = limit_size(h);
		img_dist = d;
	endtask

	function automatic int pick_size();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(MAX_WIDTH + 1, 1023);
			2: return MAX_WIDTH;
			3: return $urandom_range(1, MAX_WIDTH);
			default: return $urandom_range(1, 16);
		endcase
	endfunction

	function automatic int pick_distance();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 511;
			2: return $urandom_range(0, 511);
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	initial begin
		int phase_words;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: largest energies at an inner pixel
		write_word(5, 5, 8'd0);
		write_word(4, 5, 8'd255);
		write_word(6, 5, 8'd255);
		write_word(5, 4, 8'd255);
		write_word(5, 6, 8'd255);
		write_word(4, 4, 8'd255);
		write_word(6, 6, 8'd255);
		query_word(5, 5);
		// Corners, where neighbors clamp to the edge
		write_word(0, 0, 8'd255);
		write_word(1, 0, 8'd0);
		write_word(0, 1, 8'd0);
		write_word(1, 1, 8'd0);
		query_word(0, 0);
		query_word(511, 511);

		// Absolute differences
		drain();
		set_config(MAX_WIDTH, MAX_HEIGHT, 1, 0);
		query_word(5, 5);
		query_word(0, 0);

		// Zero distance: every neighbor is the pixel itself
		drain();
		set_config(MAX_WIDTH, MAX_HEIGHT, 0, 1);
		query_word(5, 5);

		// Zero size acts as one pixel; query far outside the image
		drain();
		set_config(0, 0, 1, 1);
		query_word(300, 400);

		// Oversized image saturates; longest distance
		drain();
		set_config(1023, 1023, 511, 1);
		query_word(5, 5);
		query_word(511, 0);

		// Random phases of settings, gaps, stalls and words
		while (words_sent < 30 + RANDOM_WORDS) begin
			drain();
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
			stall_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
			set_config(pick_size(), pick_size(), pick_distance(), $urandom_range(0, 1));
			phase_words = words_sent + $urandom_range(40, 100);
			while (words_sent < phase_words) begin
				case ($urandom_range(0, 9))
					0: write_word($urandom_range(0, 511), $urandom_range(0, 511), random_pixel());
					1: write_word($urandom_range(0, img_w - 1), $urandom_range(0, img_h - 1),
						random_pixel());
					2: query_word($urandom_range(0, 511), $urandom_range(0, 511));
					default: query_word($urandom_range(0, img_w - 1), $urandom_range(0, img_h - 1));
				endcase
			end
		end

		drain();
		if (error_count == 0)
			$display("tb_directional_difference_energy passed");
		else
			$display("tb_directional_difference_energy failed");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/dde_pkg.sv
sv/dde_frame_mem.sv
sv/directional_difference_energy.sv
bench/directional_difference_energy_checker.sv
bench/tb_directional_difference_energy.sv
